/* hw/rtl/rrb_pkg.sv */
// Shared constants for the RTP reorder buffer.
package rrb_pkg;

    // Sequence numbers above this reload the wrap hold counter.
    localparam logic [15:0] WRAP_MARK = 16'd32768;

    // Upper bound on releases caused by one input transaction.
    localparam int unsigned MAX_RESULTS = 63;
    localparam int unsigned RES_W       = 6;

    // Register map (index = byte address / 4).
    localparam logic [1:0] REG_HIGH_WATER = 2'd0;
    localparam logic [1:0] REG_LOW_WATER  = 2'd1;
    localparam logic [1:0] REG_WRAP_HOLD  = 2'd2;
    localparam logic [1:0] REG_WRAP_LOW   = 2'd3;

    // Register reset values.
    localparam logic [5:0]  HIGH_WATER_RST = 6'd48;
    localparam logic [5:0]  LOW_WATER_RST  = 6'd16;
    localparam logic [15:0] WRAP_HOLD_RST  = 16'd500;
    localparam logic [15:0] WRAP_LOW_RST   = 16'd500;

endpackage

/* hw/rtl/rrb_if.sv */
// Valid/ready channel interfaces for packet input and release output.
interface rrb_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] seq_number;
    logic [15:0] packet_tag;

    modport source (output valid, output seq_number, output packet_tag, input ready);
    modport sink   (input valid, input seq_number, input packet_tag, output ready);
endinterface

interface rrb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] released_seq;
    logic [15:0] released_tag;
    logic        last_of_run;

    modport source (output valid, output released_seq, output released_tag,
                    output last_of_run, input ready);
    modport sink   (input valid, input released_seq, input released_tag,
                    input last_of_run, output ready);
endinterface

/* hw/rtl/rrb_wrap.sv */
// Sequence number extension: hold counter, base offset and wide key.
module rrb_wrap #(
    parameter int KEY_WIDTH = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [15:0]          i_seq,
    input  logic [15:0]          i_hold,
    input  logic [15:0]          i_thr,
    output logic [KEY_WIDTH-1:0] o_key
);
    localparam logic [KEY_WIDTH-1:0] STEP = KEY_WIDTH'(65536);

    logic [15:0]          r_cnt, n_cnt;
    logic [KEY_WIDTH-1:0] r_base, n_base;
    logic                 running;

    always_comb begin
        if (i_seq > rrb_pkg::WRAP_MARK) begin
            n_cnt = i_hold;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 16'd1;
        end else begin
            n_cnt = r_cnt;
        end
        running = (n_cnt != '0);
        // counter just ran out: move to the next 64K epoch
        n_base = (!running && r_cnt != '0) ? r_base + STEP : r_base;
        o_key  = KEY_WIDTH'(i_seq) + ((running && i_seq < i_thr) ? STEP : '0) + n_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_base <= '0;
        end else if (i_step) begin
            r_cnt  <= n_cnt;
            r_base <= n_base;
        end
    end
endmodule

/* hw/rtl/rtp_reorder_buffer_core.sv */
// RTP reorder buffer top level: sorted entry store, insert and drain sequencer.
//
// Each input transaction carries a 16-bit RTP sequence number and a payload
// tag. The number is extended to a KEY_WIDTH-bit key (wrap hold counter plus
// 64K base offset) and placed into a key-sorted store held in one synchronous
// RAM organized as a circular list (head pointer + entry count). An equal key
// overwrites the stored seq/tag. When the count exceeds high_water, the
// smallest entries are released in ascending order until low_water remain
// (at most 63 per input); last_of_run flags the final release of the input.
// The input is taken in the idle state; the insert then scans downward from
// the top of the list, reading and comparing each entry, and ends at the
// first entry not larger than the new key or once it runs off the bottom; a
// decide step chooses between overwrite, drop and shift. The shift moves each
// larger entry up (read, write) and ends with a read step; the new entry is
// then written and the drain check follows; a dropped key skips shift and
// write. Each release is a RAM read and then an output register load, and
// waits while the output is stalled; a drain that finds nothing to release
// down to low_water still visits the read state. All of this is set by the
// single RAM port pair and its registered read. A new input is taken only
// once the previous one has finished, while its last release may still sit
// in the output register. The store is not cleared after reset.
module rtp_reorder_buffer_core #(
    parameter int STORE_DEPTH = 64,
    parameter int KEY_WIDTH   = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrb_in_if.sink      i_in,
    rrb_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int PW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW   = $clog2(STORE_DEPTH + 1);
    localparam int SW   = PW + 1;
    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam int EW   = KEY_WIDTH + 32;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_DECIDE   = 4'd3;
    localparam logic [3:0] S_SHIFT_RD = 4'd4;
    localparam logic [3:0] S_SHIFT_WR = 4'd5;
    localparam logic [3:0] S_PUT      = 4'd6;
    localparam logic [3:0] S_DRAIN_CK = 4'd7;
    localparam logic [3:0] S_DRAIN_RD = 4'd8;
    localparam logic [3:0] S_DRAIN_WT = 4'd9;

    // ---------------- configuration registers ----------------
    logic [5:0]  r_high, r_low;
    logic [15:0] r_hold, r_thr;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high <= rrb_pkg::HIGH_WATER_RST;
            r_low  <= rrb_pkg::LOW_WATER_RST;
            r_hold <= rrb_pkg::WRAP_HOLD_RST;
            r_thr  <= rrb_pkg::WRAP_LOW_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                rrb_pkg::REG_HIGH_WATER: r_high <= pwdata[5:0];
                rrb_pkg::REG_LOW_WATER:  r_low  <= pwdata[5:0];
                rrb_pkg::REG_WRAP_HOLD:  r_hold <= pwdata[15:0];
                rrb_pkg::REG_WRAP_LOW:   r_thr  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            rrb_pkg::REG_HIGH_WATER: prdata = {26'd0, r_high};
            rrb_pkg::REG_LOW_WATER:  prdata = {26'd0, r_low};
            rrb_pkg::REG_WRAP_HOLD:  prdata = {16'd0, r_hold};
            rrb_pkg::REG_WRAP_LOW:   prdata = {16'd0, r_thr};
            default:                 prdata = '0;
        endcase
    end

    // ---------------- key extension ----------------
    logic                 in_acc;
    logic [KEY_WIDTH-1:0] wrap_key;

    assign in_acc = i_in.valid && i_in.ready;

    rrb_wrap #(.KEY_WIDTH(KEY_WIDTH)) u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_acc),
        .i_seq   (i_in.seq_number),
        .i_hold  (r_hold),
        .i_thr   (r_thr),
        .o_key   (wrap_key)
    );

    // ---------------- entry RAM: {key, seq, tag} ----------------
    logic [EW-1:0] mem [STORE_DEPTH];
    logic [EW-1:0] r_rd_data;
    logic [PW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en, wr_en;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    logic [KEY_WIDTH-1:0] rd_key;
    logic [15:0]          rd_seq, rd_tag;
    assign rd_key = r_rd_data[EW-1:32];
    assign rd_seq = r_rd_data[31:16];
    assign rd_tag = r_rd_data[15:0];

    // ---------------- sequencer ----------------
    logic [3:0]           r_state, n_state;
    logic [PW-1:0]        r_head;
    logic [CW-1:0]        r_count, r_idx, r_pos;
    logic                 r_eq;
    logic [rrb_pkg::RES_W-1:0] r_n;
    logic [KEY_WIDTH-1:0] r_key;
    logic [15:0]          r_seq, r_tag;
    logic                 r_ovalid, r_olast;
    logic [15:0]          r_oseq, r_otag;
    logic                 out_free, more, last_now;
    logic [CW-1:0]        cnt_m1;

    // logical list position -> RAM address
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
                                           input logic [CW-1:0] l);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(l);
        if (s >= SW'(STORE_DEPTH)) begin
            s = s - SW'(STORE_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    assign out_free = !r_ovalid || o_out.ready;
    assign cnt_m1   = r_count - CW'(1);
    assign more     = (CMPW'(r_count) > CMPW'(r_low)) && (r_count != '0)
                   && (r_n < rrb_pkg::RES_W'(rrb_pkg::MAX_RESULTS));
    assign last_now = !((CMPW'(cnt_m1) > CMPW'(r_low)) && (cnt_m1 != '0)
                   && (r_n < rrb_pkg::RES_W'(rrb_pkg::MAX_RESULTS - 1)));

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.released_seq = r_oseq;
    assign o_out.released_tag = r_otag;
    assign o_out.last_of_run  = r_olast;

    // RAM port control; reads and writes of one entry never overlap in time,
    // so no forwarding is needed.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = phys(r_head, r_idx - CW'(1));
        wr_en   = 1'b0;
        wr_addr = phys(r_head, r_idx);
        wr_data = r_rd_data;
        case (r_state)
            S_SCAN_RD:  rd_en = (r_idx != '0);
            S_SHIFT_RD: rd_en = (r_idx != r_pos);
            S_SHIFT_WR: wr_en = 1'b1;
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = phys(r_head, r_pos);
                wr_data = {r_key, r_seq, r_tag};
            end
            S_DRAIN_RD: begin
                rd_en   = more && out_free;
                rd_addr = r_head;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (in_acc) n_state = S_SCAN_RD;
            S_SCAN_RD:  n_state = (r_idx == '0) ? S_DECIDE : S_SCAN_CMP;
            S_SCAN_CMP: n_state = (rd_key > r_key) ? S_SCAN_RD : S_DECIDE;
            S_DECIDE: begin
                if (r_eq) begin
                    n_state = S_PUT;
                end else if (r_count == CW'(STORE_DEPTH)) begin
                    n_state = S_DRAIN_CK;   // full: new key dropped
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: n_state = (r_idx == r_pos) ? S_PUT : S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_PUT:      n_state = S_DRAIN_CK;
            S_DRAIN_CK: n_state = (CMPW'(r_count) > CMPW'(r_high)) ? S_DRAIN_RD : S_IDLE;
            S_DRAIN_RD: begin
                if (!more) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_state = S_DRAIN_WT;
                end
            end
            S_DRAIN_WT: n_state = last_now ? S_IDLE : S_DRAIN_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_key <= wrap_key;
                    r_seq <= i_in.seq_number;
                    r_tag <= i_in.packet_tag;
                    r_idx <= r_count;
                    r_eq  <= 1'b0;
                    r_pos <= '0;
                end
                S_SCAN_CMP: begin
                    if (rd_key > r_key) begin
                        r_idx <= r_idx - CW'(1);
                    end else if (rd_key == r_key) begin
                        r_pos <= r_idx - CW'(1);
                        r_eq  <= 1'b1;
                    end else begin
                        r_pos <= r_idx;
                    end
                end
                S_DECIDE:   r_idx <= r_count;
                S_SHIFT_WR: r_idx <= r_idx - CW'(1);
                S_PUT:      if (!r_eq) r_count <= r_count + CW'(1);
                S_DRAIN_CK: r_n <= '0;
                S_DRAIN_WT: begin
                    r_ovalid <= 1'b1;
                    r_oseq   <= rd_seq;
                    r_otag   <= rd_tag;
                    r_olast  <= last_now;
                    r_head   <= phys(r_head, CW'(1));
                    r_count  <= cnt_m1;
                    r_n      <= r_n + rrb_pkg::RES_W'(1);
                end
                default: ;
            endcase
        end
    end
endmodule

/* hw/rtl/rrb_checker.sv */
// Port-level assertions for the reorder buffer, bound to the top level.
module rrb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_seq,
    input logic [15:0] out_tag,
    input logic        out_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("release dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_seq) && $stable(out_tag)
                                    && $stable(out_last))
        else $error("release payload changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid && in_ready)
        else $error("not idle after reset");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous transaction in progress");
endmodule

bind rtp_reorder_buffer_core rrb_checker u_rrb_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_seq   (o_out.released_seq),
    .out_tag   (o_out.released_tag),
    .out_last  (o_out.last_of_run)
);

/* verif/rrb_tb_pkg.sv */
// Shared testbench types for the reorder buffer verification.
`timescale 1ns / 100ps
package rrb_tb_pkg;

    typedef struct packed {
        logic [15:0] seq;
        logic [15:0] tag;
        logic        last;
    } t_release;

endpackage

/* verif/rrb_tb_if.sv */
// Configuration bus interface used by the testbench.
`timescale 1ns / 100ps
interface rrb_cfg_if;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
endinterface

/* verif/rrb_checker.sv */
// Watches the reorder buffer channels, predicts releases and compares them.
`timescale 1ns / 100ps
module rrb_scoreboard (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrb_in_if          in_ch,
    rrb_out_if         out_ch,
    rrb_cfg_if         cfg,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_release_total
);

    localparam int DEPTH = 64;

    logic [5:0]  high_w;
    logic [5:0]  low_w;
    logic [15:0] hold_reload;
    logic [15:0] wrap_low;
    logic [15:0] hold_cnt;
    logic [47:0] base_off;
    logic [47:0] keys [DEPTH];
    logic [15:0] tags [DEPTH];
    logic [15:0] seqs [DEPTH];
    int          count;

    rrb_tb_pkg::t_release expected_releases[$];

    assign o_pending = expected_releases.size();

    task automatic predict_packet(input logic [15:0] seq, input logic [15:0] tag);
        logic                 was_running;
        logic [47:0]          key;
        int                   pos;
        int                   n;
        rrb_tb_pkg::t_release r;
        was_running = hold_cnt != 0;
        key = {32'd0, seq};
        if (seq > rrb_pkg::WRAP_MARK) hold_cnt = hold_reload;
        else if (hold_cnt != 0) hold_cnt = hold_cnt - 16'd1;
        if (hold_cnt != 0) begin
            if (seq < wrap_low) key = key + 48'h10000;
        end else if (was_running) begin
            base_off = base_off + 48'h10000;
        end
        key = key + base_off;
        pos = 0;
        while (pos < count && keys[pos] < key) pos++;
        if (pos < count && keys[pos] == key) begin
            seqs[pos] = seq;
            tags[pos] = tag;
        end else if (count < DEPTH) begin
            for (int i = count; i > pos; i--) begin
                keys[i] = keys[i-1];
                tags[i] = tags[i-1];
                seqs[i] = seqs[i-1];
            end
            keys[pos] = key;
            seqs[pos] = seq;
            tags[pos] = tag;
            count++;
        end
        n = 0;
        if (count > high_w) begin
            while (count - n > low_w && n < rrb_pkg::MAX_RESULTS && n < count) n++;
            for (int i = 0; i < n; i++) begin
                r.seq  = seqs[i];
                r.tag  = tags[i];
                r.last = (i == n - 1);
                expected_releases = {expected_releases, r};
            end
            for (int i = 0; i < count - n; i++) begin
                keys[i] = keys[i+n];
                tags[i] = tags[i+n];
                seqs[i] = seqs[i+n];
            end
            count -= n;
        end
    endtask

    always @(posedge i_clk) begin
        rrb_tb_pkg::t_release exp_r;
        if (!i_rst_n) begin
            high_w      <= rrb_pkg::HIGH_WATER_RST;
            low_w       <= rrb_pkg::LOW_WATER_RST;
            hold_reload <= rrb_pkg::WRAP_HOLD_RST;
            wrap_low    <= rrb_pkg::WRAP_LOW_RST;
            hold_cnt     = '0;
            base_off     = '0;
            count        = 0;
            o_fail_count = 0;
            o_release_total = 0;
            expected_releases.delete();
        end else begin
            if (cfg.psel && cfg.penable && cfg.pwrite && cfg.pready) begin
                case (cfg.paddr[3:2])
                    rrb_pkg::REG_HIGH_WATER: high_w      <= cfg.pwdata[5:0];
                    rrb_pkg::REG_LOW_WATER:  low_w       <= cfg.pwdata[5:0];
                    rrb_pkg::REG_WRAP_HOLD:  hold_reload <= cfg.pwdata[15:0];
                    rrb_pkg::REG_WRAP_LOW:   wrap_low    <= cfg.pwdata[15:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                o_release_total++;
                if (expected_releases.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected release seq=%h tag=%h last=%b", $time,
                             out_ch.released_seq, out_ch.released_tag, out_ch.last_of_run);
                end else begin
                    exp_r = expected_releases.pop_front();
                    if (exp_r.seq !== out_ch.released_seq
                        || exp_r.tag !== out_ch.released_tag
                        || exp_r.last !== out_ch.last_of_run) begin
                        o_fail_count++;
                        $display("%0t: release mismatch expected seq=%h tag=%h last=%b,",
                                 $time, exp_r.seq, exp_r.tag, exp_r.last);
                        $display("    got seq=%h tag=%h last=%b", out_ch.released_seq,
                                 out_ch.released_tag, out_ch.last_of_run);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) predict_packet(in_ch.seq_number, in_ch.packet_tag);
        end
    end

endmodule

/* verif/tb.sv */
// Testbench top: stimulus, configuration writes and the final verdict.
`timescale 1ns / 100ps
module tb;

    logic i_clk;
    logic i_rst_n;

    rrb_in_if  pkt_in();
    rrb_out_if rel_out();
    rrb_cfg_if cfg();

    int fail_count;
    int pending;
    int release_total;
    int packets_sent;

    // Receiver control: random stalls unless a long hold-off is requested.
    bit hold_off_req;
    int stall_pct;

    rtp_reorder_buffer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pkt_in.sink),
        .o_out   (rel_out.source),
        .psel    (cfg.psel),
        .penable (cfg.penable),
        .pwrite  (cfg.pwrite),
        .paddr   (cfg.paddr),
        .pwdata  (cfg.pwdata),
        .prdata  (cfg.prdata),
        .pready  (cfg.pready)
    );

    rrb_scoreboard chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .in_ch           (pkt_in),
        .out_ch          (rel_out),
        .cfg             (cfg),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_release_total (release_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: worst case is far below this.
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // Receiver: stall pattern of its own; a long hold-off counted in cycles.
    initial begin
        int hold_cycles;
        rel_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                rel_out.ready = 1'b0;
                hold_cycles = 0;
                while (hold_cycles < 400) begin
                    @(negedge i_clk);
                    hold_cycles++;
                end
                hold_off_req = 1'b0;
            end
            rel_out.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg.psel    = 1'b1;
        cfg.penable = 1'b0;
        cfg.pwrite  = 1'b1;
        cfg.paddr   = {idx, 2'b00};
        cfg.pwdata  = val;
        @(negedge i_clk);
        cfg.penable = 1'b1;
        @(posedge i_clk);
        while (!cfg.pready) @(posedge i_clk);
        @(negedge i_clk);
        cfg.psel    = 1'b0;
        cfg.penable = 1'b0;
        cfg.pwrite  = 1'b0;
    endtask

    // Offer one packet at a falling edge; hold until accepted.
    task automatic send_packet(input logic [15:0] seq, input logic [15:0] tag);
        @(negedge i_clk);
        pkt_in.valid      = 1'b1;
        pkt_in.seq_number = seq;
        pkt_in.packet_tag = tag;
        @(posedge i_clk);
        while (!pkt_in.ready) @(posedge i_clk);
        packets_sent++;
        if (packets_sent % 9 == 0 || $urandom_range(3) == 0) begin
            @(negedge i_clk);
            pkt_in.valid = 1'b0;
            repeat ($urandom_range(6)) @(negedge i_clk);
        end
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        pkt_in.valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        // last insert may still be running; let the sequencer settle
        repeat (300) @(posedge i_clk);
    endtask

    // Mostly in-order stream with local jitter, some duplicates and noise.
    task automatic random_phase(input int n, inout logic [15:0] cur);
        logic [15:0] s;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0:       s = 16'($urandom);
                1:       s = cur - 16'($urandom_range(3));
                default: s = cur + 16'($urandom_range(4)) - 16'd1;
            endcase
            cur = cur + 16'd1;
            send_packet(s, 16'($urandom));
        end
    endtask

    initial begin
        logic [15:0] cur;
        pkt_in.valid = 1'b0;
        pkt_in.seq_number = '0;
        pkt_in.packet_tag = '0;
        cfg.psel = 1'b0;
        cfg.penable = 1'b0;
        cfg.pwrite = 1'b0;
        cfg.paddr = '0;
        cfg.pwdata = '0;
        hold_off_req = 1'b0;
        stall_pct = 30;
        packets_sent = 0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: small watermarks so drains happen early; field extremes,
        // duplicate keys, wrap-around through 65535 -> 0 and hold expiry.
        cfg_write(rrb_pkg::REG_HIGH_WATER, 32'd3);
        cfg_write(rrb_pkg::REG_LOW_WATER, 32'd0);
        cfg_write(rrb_pkg::REG_WRAP_HOLD, 32'd3);
        cfg_write(rrb_pkg::REG_WRAP_LOW, 32'd100);
        send_packet(16'h0000, 16'hFFFF);
        send_packet(16'h0000, 16'h0000);       // equal key replaces
        send_packet(16'hFFFF, 16'h5555);       // reloads hold counter
        send_packet(16'h0001, 16'hAAAA);       // wrapped while hold runs
        send_packet(16'h8000, 16'h1234);       // exactly the mark: no reload
        send_packet(16'h8001, 16'h4321);
        send_packet(16'h0002, 16'h0F0F);
        send_packet(16'h0010, 16'hF0F0);
        send_packet(16'h0011, 16'h0001);
        send_packet(16'h0012, 16'h0002);       // base already grown when the hold ran out on 0x0011
        send_packet(16'h0013, 16'h0003);
        go_idle();

        // Watermarks near the depth, zero hold reload: store fills, then drains to 62.
        cfg_write(rrb_pkg::REG_HIGH_WATER, 32'd63);
        cfg_write(rrb_pkg::REG_LOW_WATER, 32'd62);
        cfg_write(rrb_pkg::REG_WRAP_HOLD, 32'd0);
        cfg_write(rrb_pkg::REG_WRAP_LOW, 32'd65535);
        cur = 16'hF000;
        random_phase(80, cur);
        go_idle();

        // Full drain: the most releases per input.
        cfg_write(rrb_pkg::REG_HIGH_WATER, 32'd1);
        cfg_write(rrb_pkg::REG_LOW_WATER, 32'd0);
        send_packet(16'h7777, 16'hBEEF);
        go_idle();

        // Mid watermarks, longest hold reload, long receiver hold-off while packets keep coming.
        cfg_write(rrb_pkg::REG_HIGH_WATER, 32'd20);
        cfg_write(rrb_pkg::REG_LOW_WATER, 32'd4);
        cfg_write(rrb_pkg::REG_WRAP_HOLD, 32'd65535);
        cfg_write(rrb_pkg::REG_WRAP_LOW, 32'd0);
        hold_off_req = 1'b1;
        cur = 16'h7F00;
        random_phase(90, cur);
        go_idle();

        cfg_write(rrb_pkg::REG_HIGH_WATER, 32'd12);
        cfg_write(rrb_pkg::REG_LOW_WATER, 32'd5);
        cfg_write(rrb_pkg::REG_WRAP_HOLD, 32'd1);
        cfg_write(rrb_pkg::REG_WRAP_LOW, 32'd500);
        stall_pct = 0;
        cur = 16'hFF80;
        random_phase(90, cur);
        go_idle();

        cfg_write(rrb_pkg::REG_HIGH_WATER, 32'd8);
        cfg_write(rrb_pkg::REG_LOW_WATER, 32'd2);
        cfg_write(rrb_pkg::REG_WRAP_HOLD, 32'd40);
        cfg_write(rrb_pkg::REG_WRAP_LOW, 32'd2000);
        stall_pct = 60;
        cur = 16'hFFC0;
        random_phase(100, cur);
        go_idle();

        $display("Sent %0d packets over six watermark/wrap settings; %0d releases checked.",
                 packets_sent, release_total);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
